// ===== src/four_wheel_pid_speed_loop_unit_assert.svh =====
// Assertion macros shared by the checker of four_wheel_pid_speed_loop_unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FOUR_WHEEL_PID_SPEED_LOOP_UNIT_ASSERT_SVH
`define FOUR_WHEEL_PID_SPEED_LOOP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FPID_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpid assertion failed");

// Next-cycle implication.
`define FPID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpid assertion failed");

`endif

// ===== src/fpid_pkg.sv =====
// Package for the four-wheel PID speed loop: widths, register codes,
// reset values and item/control structs. No dependencies.
package fpid_pkg;

  localparam int NUM_LANES  = 4;
  localparam int NUM_STAGES = 4;

  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int ERR_W     = DATA_W + 1;
  localparam int ISUM_W    = ERR_W + 1;
  localparam int DIF_W     = ERR_W + 2;
  localparam int PERR_W    = GAIN_W + 1 + ERR_W;
  localparam int PINT_W    = GAIN_W + 1 + DATA_W;
  localparam int PDIF_W    = GAIN_W + 1 + DIF_W;
  localparam int SUM_W     = PDIF_W + 2;
  localparam int FRAC_BITS = 12;
  localparam int Q_W       = SUM_W - FRAC_BITS;
  localparam int DRIVE_MAX = 32767;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd2458;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd492;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd0;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd30000;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_a;
    logic signed [DATA_W-1:0] target_b;
    logic signed [DATA_W-1:0] target_c;
    logic signed [DATA_W-1:0] target_d;
    logic signed [DATA_W-1:0] measured_a;
    logic signed [DATA_W-1:0] measured_b;
    logic signed [DATA_W-1:0] measured_c;
    logic signed [DATA_W-1:0] measured_d;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_a;
    logic signed [DATA_W-1:0] drive_b;
    logic signed [DATA_W-1:0] drive_c;
    logic signed [DATA_W-1:0] drive_d;
  } out_item_t;

  typedef struct packed {
    logic ld_in;
    logic ld_mul;
    logic ld_sum;
    logic ld_out;
  } adv_t;

endpackage

// ===== src/fpid_pipe_ctrl.sv =====
// Valid/ready control for the four-stage lane pipeline.
// Depends on fpid_pkg.
module fpid_pipe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpid_pkg::adv_t adv_o
);

  logic [fpid_pkg::NUM_STAGES-1:0] valid_q, valid_d;
  logic [fpid_pkg::NUM_STAGES-1:0] rdy;
  logic [fpid_pkg::NUM_STAGES:0]   ld;

  always_comb begin
    rdy[3] = !valid_q[3] || out_ready_i;
    rdy[2] = !valid_q[2] || rdy[3];
    rdy[1] = !valid_q[1] || rdy[2];
    rdy[0] = !valid_q[0] || rdy[1];
    ld[0]  = in_valid_i && rdy[0];
    ld[1]  = valid_q[0] && rdy[1];
    ld[2]  = valid_q[1] && rdy[2];
    ld[3]  = valid_q[2] && rdy[3];
    ld[4]  = valid_q[3] && out_ready_i;
    for (int k = 0; k < fpid_pkg::NUM_STAGES; k++) begin
      valid_d[k] = ld[k] || (valid_q[k] && !ld[k+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o    = rdy[0];
  assign out_valid_o   = valid_q[3];
  assign adv_o.ld_in   = ld[0];
  assign adv_o.ld_mul  = ld[1];
  assign adv_o.ld_sum  = ld[2];
  assign adv_o.ld_out  = ld[3];

endmodule

// ===== src/fpid_lane.sv =====
// One PID lane: error history and clamped integral, gain products,
// sum, then truncation and saturation. Depends on fpid_pkg.
module fpid_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fpid_pkg::adv_t                      adv_i,
  input  logic signed [fpid_pkg::DATA_W-1:0]  target_i,
  input  logic signed [fpid_pkg::DATA_W-1:0]  measured_i,
  input  logic        [fpid_pkg::GAIN_W-1:0]  prop_gain_i,
  input  logic        [fpid_pkg::GAIN_W-1:0]  integ_gain_i,
  input  logic        [fpid_pkg::GAIN_W-1:0]  deriv_gain_i,
  input  logic        [fpid_pkg::LIM_W-1:0]   integ_limit_i,
  output logic signed [fpid_pkg::DATA_W-1:0]  drive_o
);

  localparam int DW = fpid_pkg::DATA_W;
  localparam int EW = fpid_pkg::ERR_W;
  localparam int IW = fpid_pkg::ISUM_W;
  localparam int FW = fpid_pkg::DIF_W;
  localparam int SW = fpid_pkg::SUM_W;
  localparam int QW = fpid_pkg::Q_W;
  localparam int FB = fpid_pkg::FRAC_BITS;
  localparam logic signed [QW-1:0] QMAX = QW'(fpid_pkg::DRIVE_MAX);
  localparam logic signed [QW-1:0] QMIN = -QMAX;
  localparam logic signed [SW-1:0] BIAS = SW'((1 << FB) - 1);

  // per-lane loop state
  logic signed [DW-1:0] integ_q;
  logic signed [EW-1:0] prev_q, older_q;

  logic signed [EW-1:0] err_d;
  logic signed [IW-1:0] isum, lim_pos, lim_neg;
  logic signed [DW-1:0] integ_d;
  logic signed [FW-1:0] dif_d;

  logic signed [EW-1:0] s1_err_q;
  logic signed [DW-1:0] s1_int_q;
  logic signed [FW-1:0] s1_dif_q;

  logic signed [fpid_pkg::PERR_W-1:0] p_err_d, p_err_q;
  logic signed [fpid_pkg::PINT_W-1:0] p_int_d, p_int_q;
  logic signed [fpid_pkg::PDIF_W-1:0] p_dif_d, p_dif_q;

  logic signed [SW-1:0] sum_d, sum_q, rnd;
  logic signed [QW-1:0] quo;

  always_comb begin
    err_d   = $signed({target_i[DW-1], target_i}) - $signed({measured_i[DW-1], measured_i});
    isum    = $signed({{(IW-DW){integ_q[DW-1]}}, integ_q}) + $signed({err_d[EW-1], err_d});
    lim_pos = $signed({{(IW-fpid_pkg::LIM_W){1'b0}}, integ_limit_i});
    lim_neg = -lim_pos;
    if (isum > lim_pos) begin
      integ_d = lim_pos[DW-1:0];
    end else if (isum < lim_neg) begin
      integ_d = lim_neg[DW-1:0];
    end else begin
      integ_d = isum[DW-1:0];
    end
    dif_d = $signed({{(FW-EW){err_d[EW-1]}}, err_d})
          - $signed({{(FW-EW-1){prev_q[EW-1]}}, prev_q, 1'b0})
          + $signed({{(FW-EW){older_q[EW-1]}}, older_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      older_q <= '0;
    end else if (adv_i.ld_in) begin
      integ_q <= integ_d;
      prev_q  <= err_d;
      older_q <= prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_in) begin
      s1_err_q <= err_d;
      s1_int_q <= integ_d;
      s1_dif_q <= dif_d;
    end
  end

  always_comb begin
    p_err_d = $signed({1'b0, prop_gain_i})  * s1_err_q;
    p_int_d = $signed({1'b0, integ_gain_i}) * s1_int_q;
    p_dif_d = $signed({1'b0, deriv_gain_i}) * s1_dif_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_mul) begin
      p_err_q <= p_err_d;
      p_int_q <= p_int_d;
      p_dif_q <= p_dif_d;
    end
  end

  assign sum_d = SW'(p_err_q) + SW'(p_int_q) + SW'(p_dif_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  // divide by 2^FB toward zero, then saturate symmetrically
  always_comb begin
    rnd = sum_q[SW-1] ? (sum_q + BIAS) : sum_q;
    quo = rnd[SW-1:FB];
    if (quo > QMAX) begin
      drive_o = QMAX[DW-1:0];
    end else if (quo < QMIN) begin
      drive_o = QMIN[DW-1:0];
    end else begin
      drive_o = quo[DW-1:0];
    end
  end

endmodule

// ===== src/four_wheel_pid_speed_loop_unit.sv =====
// Four-wheel PID speed loop, top level: config registers, lanes, output merge.
// Depends on fpid_pkg, fpid_pipe_ctrl, fpid_lane.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one item with a
//   target and a measured speed per wheel. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns one item with four drives.
//   Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 prop gain, 1 integral gain, 2 derivative gain, 3 integral limit);
//   write only while no item is in flight.
//   An accepted item passes through the four-stage lane pipeline
//   (history/integral, multiply, sum, output reg) to output valid; the four
//   lanes run side by side and a new item can be taken every cycle while the receiver keeps taking results.
//   Reset loads the default gains and limit, clears every lane's integral
//   and error history and empties the pipeline.
//   When the receiver stalls the pipeline fills; up to four items are held
//   and in_ready_o falls once all stages are occupied.
module four_wheel_pid_speed_loop_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fpid_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fpid_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fpid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpid_pkg::GAIN_W-1:0]         cfg_wdata_i
);

  localparam int NL = fpid_pkg::NUM_LANES;
  localparam int DW = fpid_pkg::DATA_W;

  logic [fpid_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [fpid_pkg::LIM_W-1:0]  integ_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= fpid_pkg::PROP_GAIN_RST;
      integ_gain_q  <= fpid_pkg::INTEG_GAIN_RST;
      deriv_gain_q  <= fpid_pkg::DERIV_GAIN_RST;
      integ_limit_q <= fpid_pkg::INTEG_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpid_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i;
        fpid_pkg::CFG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i;
        fpid_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_wdata_i;
        fpid_pkg::CFG_INTEG_LIMIT: integ_limit_q <= cfg_wdata_i[fpid_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  fpid_pkg::adv_t adv;

  fpid_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .adv_o      (adv)
  );

  logic signed [DW-1:0] tgt   [NL];
  logic signed [DW-1:0] meas  [NL];
  logic signed [DW-1:0] drive [NL];

  assign tgt[0]  = in_data_i.target_a;
  assign tgt[1]  = in_data_i.target_b;
  assign tgt[2]  = in_data_i.target_c;
  assign tgt[3]  = in_data_i.target_d;
  assign meas[0] = in_data_i.measured_a;
  assign meas[1] = in_data_i.measured_b;
  assign meas[2] = in_data_i.measured_c;
  assign meas[3] = in_data_i.measured_d;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    fpid_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .target_i     (tgt[l]),
      .measured_i   (meas[l]),
      .prop_gain_i  (prop_gain_q),
      .integ_gain_i (integ_gain_q),
      .deriv_gain_i (deriv_gain_q),
      .integ_limit_i(integ_limit_q),
      .drive_o      (drive[l])
    );
  end

  // merge the lane results into the output item register
  fpid_pkg::out_item_t out_data_q, out_data_d;

  always_comb begin
    out_data_d.drive_a = drive[0];
    out_data_d.drive_b = drive[1];
    out_data_d.drive_c = drive[2];
    out_data_d.drive_d = drive[3];
  end

  always_ff @(posedge clk_i) begin
    if (adv.ld_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_data_o = out_data_q;

endmodule

// ===== src/fpid_checker.sv =====
// Port-level checker for four_wheel_pid_speed_loop_unit, bound to the top.
// Depends on fpid_pkg and four_wheel_pid_speed_loop_unit_assert.svh.
`include "four_wheel_pid_speed_loop_unit_assert.svh"

module fpid_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fpid_pkg::out_item_t out_data_o
);

  logic [2:0] cnt_q, cnt_d;
  logic       in_acc, out_acc, sat_ok;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign sat_ok  = (out_data_o.drive_a != 16'h8000) && (out_data_o.drive_b != 16'h8000)
                && (out_data_o.drive_c != 16'h8000) && (out_data_o.drive_d != 16'h8000);

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `FPID_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `FPID_ASSERT_IMPLY(a_no_orphan, out_valid_o, cnt_q != 3'd0)
  `FPID_ASSERT_IMPLY(a_depth, 1'b1, cnt_q <= 3'(fpid_pkg::NUM_STAGES))
  `FPID_ASSERT_IMPLY(a_symm_sat, out_valid_o, sat_ok)

endmodule

bind four_wheel_pid_speed_loop_unit fpid_checker u_fpid_checker (.*);

// ===== dv/four_wheel_pid_speed_loop_unit_tb.sv =====
// Self-checking testbench for four_wheel_pid_speed_loop_unit: four-lane PID drive prediction,
// random valid/ready idling on both channels and gain/limit reprogramming between phases.
// Depends on fpid_pkg and the four_wheel_pid_speed_loop_unit RTL.
module four_wheel_pid_speed_loop_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpid_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 244;
  localparam int RAND_PHASES  = 8;
  localparam int SETTLE_TICKS = 8;

  class pid_scoreboard;
    bit [GAIN_W-1:0]           kp, ki, kd;
    bit [LIM_W-1:0]            ilim;
    logic signed [DATA_W-1:0]  integ_st [NUM_LANES];
    logic signed [ERR_W-1:0]   prev_err [NUM_LANES];
    logic signed [ERR_W-1:0]   old_err  [NUM_LANES];
    out_item_t                 drive_q[$];
    int                        failures;

    function new();
      kp   = PROP_GAIN_RST;
      ki   = INTEG_GAIN_RST;
      kd   = DERIV_GAIN_RST;
      ilim = INTEG_LIMIT_RST;
      foreach (integ_st[i]) begin
        integ_st[i] = '0;
        prev_err[i] = '0;
        old_err[i]  = '0;
      end
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_PROP_GAIN:   kp = data;
        CFG_INTEG_GAIN:  ki = data;
        CFG_DERIV_GAIN:  kd = data;
        CFG_INTEG_LIMIT: ilim = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      logic signed [DATA_W-1:0] tgt [NUM_LANES];
      logic signed [DATA_W-1:0] meas [NUM_LANES];
      logic signed [DATA_W-1:0] drv [NUM_LANES];
      longint err, isum, dif, acc, q, lim;
      out_item_t want;
      tgt  = '{it.target_a, it.target_b, it.target_c, it.target_d};
      meas = '{it.measured_a, it.measured_b, it.measured_c, it.measured_d};
      lim  = longint'(ilim);
      for (int i = 0; i < NUM_LANES; i++) begin
        err  = longint'(tgt[i]) - longint'(meas[i]);
        isum = longint'(integ_st[i]) + err;
        if (isum > lim) isum = lim;
        if (isum < -lim) isum = -lim;
        dif = err - 2 * longint'(prev_err[i]) + longint'(old_err[i]);
        acc = longint'(kp) * err + longint'(ki) * isum + longint'(kd) * dif;
        q   = acc / (longint'(1) << FRAC_BITS);
        if (q > longint'(DRIVE_MAX)) q = longint'(DRIVE_MAX);
        if (q < -longint'(DRIVE_MAX)) q = -longint'(DRIVE_MAX);
        drv[i]      = q[DATA_W-1:0];
        integ_st[i] = isum[DATA_W-1:0];
        old_err[i]  = prev_err[i];
        prev_err[i] = err[ERR_W-1:0];
      end
      want.drive_a = drv[0];
      want.drive_b = drv[1];
      want.drive_c = drv[2];
      want.drive_d = drv[3];
      drive_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      logic signed [DATA_W-1:0] w [NUM_LANES];
      logic signed [DATA_W-1:0] g [NUM_LANES];
      string names [NUM_LANES];
      names = '{"drive_a", "drive_b", "drive_c", "drive_d"};
      if (drive_q.size() == 0) begin
        $error("unexpected output item: %0d %0d %0d %0d",
               got.drive_a, got.drive_b, got.drive_c, got.drive_d);
        failures++;
        return;
      end
      want = drive_q.pop_front();
      w = '{want.drive_a, want.drive_b, want.drive_c, want.drive_d};
      g = '{got.drive_a, got.drive_b, got.drive_c, got.drive_d};
      for (int i = 0; i < NUM_LANES; i++) begin
        if (g[i] !== w[i]) begin
          $error("%s mismatch: expected %0d, actual %0d", names[i], w[i], g[i]);
          failures++;
        end
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;

  pid_scoreboard sb;
  int            cycles = 0;
  int            tx_calm = 0;
  int            rx_calm = 0;

  four_wheel_pid_speed_loop_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("four_wheel_pid_speed_loop_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // mostly random gaps, with occasional stretches of back-to-back items
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_speed();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3, 4: return DATA_W'($urandom_range(0, 65535));
      default: return DATA_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic signed [DATA_W-1:0] t [NUM_LANES];
    logic signed [DATA_W-1:0] m [NUM_LANES];
    int near;
    in_item_t it;
    for (int i = 0; i < NUM_LANES; i++) begin
      t[i] = rand_speed();
      if ($urandom_range(0, 3) == 0) begin
        m[i] = rand_speed();
      end else begin
        // measured speed tracking the target closely
        near = int'(t[i]) + int'($urandom_range(0, 400)) - 200;
        if (near > 32767) near = 32767;
        if (near < -32768) near = -32768;
        m[i] = near[DATA_W-1:0];
      end
    end
    it.target_a = t[0];  it.measured_a = m[0];
    it.target_b = t[1];  it.measured_b = m[1];
    it.target_c = t[2];  it.measured_c = m[2];
    it.target_d = t[3];  it.measured_d = m[3];
    return it;
  endfunction

  // lanes see (t,m), (m,t), (t,0) and (0,m)
  function automatic in_item_t pair_item(logic signed [DATA_W-1:0] t,
                                         logic signed [DATA_W-1:0] m);
    in_item_t it;
    it.target_a = t;   it.measured_a = m;
    it.target_b = m;   it.measured_b = t;
    it.target_c = t;   it.measured_c = '0;
    it.target_d = '0;  it.measured_d = m;
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(0, 8191));
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'hFFFF;
      2: return GAIN_W'($urandom_range(0, 500));
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic take_result();
    int gap;
    gap = draw_gap(rx_calm);
    if (gap > 0) begin
      out_ready <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    out_ready <= 1'b1;
    do @(posedge clk_i); while (!out_valid);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  task automatic cfg_off();
    cfg_we <= 1'b0;
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever take_result();
  end

  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PROP_GAIN;
    cfg_wdata = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset gains: full-range errors, integral and output saturation
    send_item(pair_item(16'sd0, 16'sd0));
    send_item(pair_item(16'sh7FFF, 16'sh8000));
    send_item(pair_item(16'sh7FFF, 16'sh8000));
    send_item(pair_item(16'sh8000, 16'sh7FFF));
    send_item(pair_item(16'sh8000, 16'sh8000));
    send_item(pair_item(16'sh7FFF, 16'sh7FFF));
    send_item(pair_item(16'sh5555, 16'shAAAA));
    send_item(pair_item(16'shAAAA, 16'sh5555));

    // all gains at max; limit written with bit 15 set
    settle();
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_DERIV_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_LIMIT, 16'hFFFF);
    cfg_off();
    send_item(pair_item(16'sh7FFF, 16'sh8000));
    send_item(pair_item(16'sh7FFF, 16'sh8000));
    send_item(pair_item(16'sh8000, 16'sh7FFF));
    send_item(pair_item(16'sd1, 16'sd0));

    // derivative term alone
    settle();
    write_reg(CFG_PROP_GAIN, 16'd0);
    write_reg(CFG_INTEG_GAIN, 16'd0);
    write_reg(CFG_DERIV_GAIN, 16'd4096);
    cfg_off();
    send_item(pair_item(16'sd100, 16'sd0));
    send_item(pair_item(-16'sd100, 16'sd0));
    send_item(pair_item(16'sh7FFF, 16'sh8000));

    // limit lowered below a stored integral
    settle();
    write_reg(CFG_INTEG_GAIN, 16'd4096);
    write_reg(CFG_DERIV_GAIN, 16'd0);
    write_reg(CFG_INTEG_LIMIT, 16'h7FFF);
    cfg_off();
    send_item(pair_item(16'sh7FFF, 16'sh8000));
    settle();
    write_reg(CFG_INTEG_LIMIT, 16'd50);
    cfg_off();
    send_item(pair_item(16'sd0, 16'sd0));
    send_item(pair_item(16'sd0, 16'sd0));

    // zero limit
    settle();
    write_reg(CFG_INTEG_LIMIT, 16'd0);
    cfg_off();
    send_item(pair_item(16'sd1000, -16'sd1000));
    send_item(pair_item(-16'sd5, 16'sd5));

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_reg(CFG_PROP_GAIN, rand_gain());
      write_reg(CFG_INTEG_GAIN, rand_gain());
      write_reg(CFG_DERIV_GAIN, rand_gain());
      write_reg(CFG_INTEG_LIMIT, rand_limit());
      cfg_off();
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
    end

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("four_wheel_pid_speed_loop_unit_tb: PASS");
    end else begin
      $display("four_wheel_pid_speed_loop_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
